// ===== rtl/necd_pkg.sv =====
// Shared types and constants for the NEC IR frame decoder.
// No dependencies; imported by every module of the block.
package necd_pkg;

  localparam int unsigned WIDTH_W     = 17;
  localparam int unsigned FIELD_W     = 16;
  localparam int unsigned FIELD_BITS_DEF = 16;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 17;
  localparam int unsigned SHORT_W     = 12;
  localparam int unsigned LEAD_W      = 14;
  localparam int unsigned QUEUE_DEPTH = 2;

  // fixed leader windows, exclusive bounds
  localparam logic [WIDTH_W-1:0] NEW_HIGH_MIN = 17'd4000;
  localparam logic [WIDTH_W-1:0] NEW_HIGH_MAX = 17'd5000;
  localparam logic [WIDTH_W-1:0] REP_HIGH_MIN = 17'd2000;
  localparam logic [WIDTH_W-1:0] REP_HIGH_MAX = 17'd2500;
  localparam logic [WIDTH_W-1:0] REP_LOW_MIN  = 17'd500;
  localparam logic [WIDTH_W-1:0] REP_LOW_MAX  = 17'd700;
  localparam logic [FIELD_W-1:0] NO_KEY_CODE  = 16'hffff;

  // register reset values
  localparam logic [WIDTH_W-1:0] IDLE_TIMEOUT_RST = 17'd100000;
  localparam logic [SHORT_W-1:0] BIT_MIN_RST      = 12'd350;
  localparam logic [SHORT_W-1:0] BIT_MAX_RST      = 12'd850;
  localparam logic [SHORT_W-1:0] ONE_MIN_RST      = 12'd1350;
  localparam logic [SHORT_W-1:0] ONE_MAX_RST      = 12'd1950;
  localparam logic [LEAD_W-1:0]  LEAD_MIN_RST     = 14'd5000;
  localparam logic [LEAD_W-1:0]  LEAD_MAX_RST     = 14'd10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IDLE_TIMEOUT = 3'd0,
    CFG_BIT_MIN      = 3'd1,
    CFG_BIT_MAX      = 3'd2,
    CFG_ONE_MIN      = 3'd3,
    CFG_ONE_MAX      = 3'd4,
    CFG_LEAD_MIN     = 3'd5,
    CFG_LEAD_MAX     = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_LEAD_HIGH = 4'd1,
    PH_REP_LOW   = 4'd2,
    PH_BIT_LOW   = 4'd3,
    PH_BIT_HIGH  = 4'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_FRAME   = 2'd0,
    KIND_REPEAT  = 2'd1,
    KIND_TIMEOUT = 2'd2,
    KIND_BAD     = 2'd3
  } kind_t;

  typedef struct packed {
    logic               pulse_level;
    logic [WIDTH_W-1:0] pulse_width_us;
  } in_item_t;

  typedef struct packed {
    kind_t              result_kind;
    logic [FIELD_W-1:0] frame_address;
    logic [FIELD_W-1:0] key_code;
  } out_item_t;

  // pulse after window classification
  typedef struct packed {
    logic level;
    logic lead_ok;
    logic new_high;
    logic rep_high;
    logic rep_low;
    logic bit_short;
    logic bit_one;
    logic timeout;
  } pulse_cls_t;

  function automatic logic in_window(input logic [WIDTH_W-1:0] w,
                                     input logic [WIDTH_W-1:0] lo,
                                     input logic [WIDTH_W-1:0] hi);
    return (w > lo) && (w < hi);
  endfunction

endpackage

// ===== rtl/necd_front.sv =====
// Front end: configuration registers and pulse window classification.
// Depends on necd_pkg.
module necd_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [necd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [necd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  necd_pkg::in_item_t                  in_data,
  output logic                                push_valid,
  input  logic                                push_ready,
  output necd_pkg::pulse_cls_t                push_data
);
  import necd_pkg::*;

  logic [WIDTH_W-1:0] idle_timeout_r;
  logic [SHORT_W-1:0] bit_min_r, bit_max_r, one_min_r, one_max_r;
  logic [LEAD_W-1:0]  lead_min_r, lead_max_r;
  logic [WIDTH_W-1:0] w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_timeout_r <= IDLE_TIMEOUT_RST;
      bit_min_r      <= BIT_MIN_RST;
      bit_max_r      <= BIT_MAX_RST;
      one_min_r      <= ONE_MIN_RST;
      one_max_r      <= ONE_MAX_RST;
      lead_min_r     <= LEAD_MIN_RST;
      lead_max_r     <= LEAD_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDLE_TIMEOUT: idle_timeout_r <= cfg_wdata[WIDTH_W-1:0];
        CFG_BIT_MIN:      bit_min_r      <= cfg_wdata[SHORT_W-1:0];
        CFG_BIT_MAX:      bit_max_r      <= cfg_wdata[SHORT_W-1:0];
        CFG_ONE_MIN:      one_min_r      <= cfg_wdata[SHORT_W-1:0];
        CFG_ONE_MAX:      one_max_r      <= cfg_wdata[SHORT_W-1:0];
        CFG_LEAD_MIN:     lead_min_r     <= cfg_wdata[LEAD_W-1:0];
        CFG_LEAD_MAX:     lead_max_r     <= cfg_wdata[LEAD_W-1:0];
        default: ;
      endcase
    end
  end

  assign w          = in_data.pulse_width_us;
  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    push_data.level     = in_data.pulse_level;
    push_data.lead_ok   = in_window(w, WIDTH_W'(lead_min_r), WIDTH_W'(lead_max_r));
    push_data.new_high  = in_window(w, NEW_HIGH_MIN, NEW_HIGH_MAX);
    push_data.rep_high  = in_window(w, REP_HIGH_MIN, REP_HIGH_MAX);
    push_data.rep_low   = in_window(w, REP_LOW_MIN, REP_LOW_MAX);
    push_data.bit_short = in_window(w, WIDTH_W'(bit_min_r), WIDTH_W'(bit_max_r));
    push_data.bit_one   = in_window(w, WIDTH_W'(one_min_r), WIDTH_W'(one_max_r));
    push_data.timeout   = w > idle_timeout_r;
  end

endmodule

// ===== rtl/necd_queue.sv =====
// Short FIFO of classified pulses between front and back end.
// Depends on necd_pkg.
module necd_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  necd_pkg::pulse_cls_t  push_data,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output necd_pkg::pulse_cls_t  pop_data
);
  import necd_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  pulse_cls_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = count_r != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/necd_back.sv =====
// Back end: frame state machine, bit shifters, stored fields, result register.
// Depends on necd_pkg.
module necd_back #(
  parameter int unsigned FIELD_BITS = necd_pkg::FIELD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  necd_pkg::pulse_cls_t  pop_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output necd_pkg::out_item_t   out_data
);
  import necd_pkg::*;

  localparam int unsigned BI_W  = $clog2(2 * FIELD_BITS);
  localparam int unsigned POS_W = $clog2(FIELD_BITS);

  phase_t                 phase_r, phase_nxt;
  logic [BI_W-1:0]        bit_index_r, bit_index_nxt;
  logic                   low_valid_r, low_valid_nxt;
  logic [FIELD_BITS-1:0]  addr_sh_r, addr_sh_nxt, code_sh_r, code_sh_nxt;
  logic [FIELD_BITS-1:0]  st_addr_r, st_addr_nxt, st_code_r, st_code_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  logic                   take;
  pulse_cls_t             c;
  logic                   in_addr;
  logic                   last_bit;
  logic                   bad_bit;
  logic                   bit_val;
  logic [BI_W-1:0]        code_off;
  logic [POS_W-1:0]       addr_pos, code_pos;
  logic [FIELD_BITS-1:0]  addr_upd, code_upd;

  assign c         = pop_data;
  assign pop_ready = !out_valid_r || out_ready;
  assign take      = pop_valid && pop_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_addr  = bit_index_r < BI_W'(FIELD_BITS);
  assign last_bit = bit_index_r == BI_W'(2 * FIELD_BITS - 1);
  assign code_off = bit_index_r - BI_W'(FIELD_BITS);
  assign addr_pos = bit_index_r[POS_W-1:0];
  assign code_pos = code_off[POS_W-1:0];
  assign bit_val  = !c.bit_short;
  assign addr_upd = addr_sh_r | (FIELD_BITS'(bit_val) << addr_pos);
  assign code_upd = code_sh_r | (FIELD_BITS'(bit_val) << code_pos);

  // any malformed pulse inside the data bits
  always_comb begin
    bad_bit = 1'b0;
    unique case (phase_r)
      PH_BIT_LOW:  bad_bit = c.level || !c.bit_short;
      PH_BIT_HIGH: bad_bit = !c.level || !low_valid_r || (!c.bit_short && !c.bit_one);
      default:     bad_bit = 1'b0;
    endcase
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (take) begin
      unique case (phase_r)
        PH_LEAD_HIGH: begin
          if (c.level && c.new_high) phase_nxt = PH_BIT_LOW;
          else if (c.level && c.rep_high) phase_nxt = PH_REP_LOW;
          else phase_nxt = PH_IDLE;
        end
        PH_REP_LOW: phase_nxt = PH_IDLE;
        PH_BIT_LOW: phase_nxt = bad_bit ? PH_IDLE : PH_BIT_HIGH;
        PH_BIT_HIGH: phase_nxt = (bad_bit || last_bit) ? PH_IDLE : PH_BIT_LOW;
        default: phase_nxt = (!c.level && c.lead_ok) ? PH_LEAD_HIGH : PH_IDLE;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    bit_index_nxt = bit_index_r;
    low_valid_nxt = low_valid_r;
    addr_sh_nxt   = addr_sh_r;
    code_sh_nxt   = code_sh_r;
    st_addr_nxt   = st_addr_r;
    st_code_nxt   = st_code_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (take) begin
      unique case (phase_r)
        PH_LEAD_HIGH: begin
          if (c.level && c.new_high) begin
            addr_sh_nxt   = '0;
            code_sh_nxt   = '0;
            bit_index_nxt = '0;
            low_valid_nxt = 1'b0;
          end else if (!(c.level && c.rep_high)) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{KIND_BAD, FIELD_W'(st_addr_r), '0};
          end
        end
        PH_REP_LOW: begin
          out_valid_nxt = 1'b1;
          if (!c.level && c.rep_low) begin
            out_data_nxt = '{KIND_REPEAT, FIELD_W'(st_addr_r), FIELD_W'(st_code_r)};
          end else begin
            out_data_nxt = '{KIND_BAD, FIELD_W'(st_addr_r), '0};
          end
        end
        PH_BIT_LOW, PH_BIT_HIGH: begin
          if (bad_bit || (last_bit && phase_r == PH_BIT_HIGH)) begin
            // frame ends; an invalid bit wipes the current and later fields
            if (bad_bit) begin
              st_addr_nxt = in_addr ? '0 : addr_sh_r;
              st_code_nxt = '0;
            end else begin
              st_addr_nxt = addr_sh_r;
              st_code_nxt = code_upd;
            end
            addr_sh_nxt   = st_addr_nxt;
            code_sh_nxt   = st_code_nxt;
            bit_index_nxt = '0;
            low_valid_nxt = 1'b0;
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{KIND_FRAME, FIELD_W'(st_addr_nxt), FIELD_W'(st_code_nxt)};
          end else if (phase_r == PH_BIT_LOW) begin
            low_valid_nxt = 1'b1;
          end else begin
            if (in_addr) addr_sh_nxt = addr_upd;
            else code_sh_nxt = code_upd;
            bit_index_nxt = bit_index_r + 1'b1;
            low_valid_nxt = 1'b0;
          end
        end
        default: begin
          if (c.level) begin
            if (c.timeout) begin
              st_code_nxt   = FIELD_BITS'(NO_KEY_CODE);
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{KIND_TIMEOUT, FIELD_W'(st_addr_r), '0};
            end
          end else if (!c.lead_ok) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{KIND_BAD, FIELD_W'(st_addr_r), '0};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_index_r <= '0;
      low_valid_r <= 1'b0;
      addr_sh_r   <= '0;
      code_sh_r   <= '0;
      st_addr_r   <= '0;
      st_code_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      bit_index_r <= bit_index_nxt;
      low_valid_r <= low_valid_nxt;
      addr_sh_r   <= addr_sh_nxt;
      code_sh_r   <= code_sh_nxt;
      st_addr_r   <= st_addr_nxt;
      st_code_r   <= st_code_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== rtl/nec_ir_frame_decoder.sv =====
// NEC IR frame decoder, top level: front classifier, pulse queue, back-end FSM.
// Path of a pulse: the queue writes it at the accepting edge, then the back-end FSM
// steps on it and registers the result; a stalled output can hold it in the queue.
// Throughput: 1 pulse per cycle unless the output stalls; the back-end FSM takes
// one queued pulse per cycle likewise; the 2-entry queue and output register absorb stalls.
// Reset (synchronous, rst_n low): registers return to defaults, FSM idle,
// stored address and code cleared, queue and output emptied.
module nec_ir_frame_decoder #(
  parameter int unsigned FIELD_BITS = necd_pkg::FIELD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [necd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [necd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  necd_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output necd_pkg::out_item_t              out_data
);
  import necd_pkg::*;

  logic        push_valid, push_ready, pop_valid, pop_ready;
  pulse_cls_t  push_data, pop_data;

  necd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  necd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  necd_back #(
    .FIELD_BITS (FIELD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
